// ===== src/tcce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

   // Widths of the channel fields and configuration registers.
   localparam int OP_W         = 1;
   localparam int CHAR_W       = 8;
   localparam int COL_FIELD_W  = 7;
   localparam int ROW_FIELD_W  = 6;
   localparam int COLS_CFG_W   = 8;
   localparam int ROWS_CFG_W   = 7;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 8;

   // Width used for all column and row comparisons; covers every grid size.
   localparam int CMP_W        = 10;

   localparam int TAB_STOP     = 4;

   localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd80;
   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd25;

   localparam logic [OP_W-1:0] OP_CHAR = 1'b0;
   localparam logic [OP_W-1:0] OP_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'b1;

   localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_HT    = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_VT    = 8'h0B;
   localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_COPY,
      ST_COPY_END,
      ST_FILL,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SCAN_CLEAR,
      SCAN_COPY,
      SCAN_FILL
   } scan_mode_type;

   typedef struct packed {
      logic          accept;
      logic          scan_start;
      logic          scan_step;
      scan_mode_type mode;
      logic          out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_clear;
      logic need_copy;
      logic need_fill;
      logic scan_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/tcce_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tcce_req_if import tcce_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [CHAR_W-1:0]      char_code;
   logic [COL_FIELD_W-1:0] read_col;
   logic [ROW_FIELD_W-1:0] read_row;

   modport source (output valid, operation, char_code, read_col, read_row, input ready);
   modport sink (input valid, operation, char_code, read_col, read_row, output ready);
endinterface

interface tcce_rsp_if import tcce_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COL_FIELD_W-1:0] cursor_col;
   logic [ROW_FIELD_W-1:0] cursor_row;
   logic [CHAR_W-1:0]      cell_value;
   logic                   read_out_of_range;

   modport source (output valid, cursor_col, cursor_row, cell_value, read_out_of_range,
                   input ready);
   modport sink (input valid, cursor_col, cursor_row, cell_value, read_out_of_range,
                 output ready);
endinterface

interface tcce_csr_if import tcce_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/text_console_cell_engine_top.sv =====
// Character and read items: the result is loaded into the output registers from the
// done state, which waits while an earlier response is still held; no new item is taken
// until then. A new line past the bottom row adds a scroll copy and blank fill (only
// the blank fill with a single row in use); form feed adds a clear of all
// MAX_COLS * MAX_ROWS cells. After reset all cells of the store are cleared, during
// which no item is taken; registers are writable.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cell_engine_top import tcce_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input wire logic clock,
   input wire logic reset,
   tcce_req_if.sink   req_chan,
   tcce_rsp_if.source rsp_chan,
   tcce_csr_if.sink   csr_chan
);

   ctl_cmd_type   cmd;
   dp_status_type status;
   logic          csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid & csr_chan.ready;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tcce_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write             (csr_write),
      .csr_index             (csr_chan.index),
      .csr_data              (csr_chan.data),
      .req_operation         (req_chan.operation),
      .req_char_code         (req_chan.char_code),
      .req_read_col          (req_chan.read_col),
      .req_read_row          (req_chan.read_row),
      .rsp_cursor_col        (rsp_chan.cursor_col),
      .rsp_cursor_row        (rsp_chan.cursor_row),
      .rsp_cell_value        (rsp_chan.cell_value),
      .rsp_read_out_of_range (rsp_chan.read_out_of_range)
   );

endmodule

`default_nettype wire

// ===== src/tcce_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcce_ctrl import tcce_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output ctl_cmd_type        cmd,
   input  wire dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.accept     = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.scan_step  = 1'b0;
      cmd.mode       = SCAN_CLEAR;
      cmd.out_load   = 1'b0;

      case (state_ff)
         ST_INIT: begin
            cmd.scan_step = 1'b1;
            cmd.mode      = SCAN_CLEAR;
            if (status.scan_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.need_clear) begin
                  cmd.scan_start = 1'b1;
                  cmd.mode       = SCAN_CLEAR;
                  state_in       = ST_CLEAR;
               end else if (status.need_copy) begin
                  cmd.scan_start = 1'b1;
                  cmd.mode       = SCAN_COPY;
                  state_in       = ST_COPY;
               end else if (status.need_fill) begin
                  cmd.scan_start = 1'b1;
                  cmd.mode       = SCAN_FILL;
                  state_in       = ST_FILL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CLEAR: begin
            cmd.scan_step = 1'b1;
            cmd.mode      = SCAN_CLEAR;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            cmd.scan_step = 1'b1;
            cmd.mode      = SCAN_COPY;
            if (status.scan_last) begin
               state_in = ST_COPY_END;
            end
         end
         ST_COPY_END: begin
            // The last copied cell is written in this cycle.
            cmd.scan_start = 1'b1;
            cmd.mode       = SCAN_FILL;
            state_in       = ST_FILL;
         end
         ST_FILL: begin
            cmd.scan_step = 1'b1;
            cmd.mode      = SCAN_FILL;
            if (status.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/tcce_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcce_dp import tcce_pkg::*; #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctl_cmd_type            cmd,
   output dp_status_type               status,
   input  wire logic                   csr_write,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic [OP_W-1:0]        req_operation,
   input  wire logic [CHAR_W-1:0]      req_char_code,
   input  wire logic [COL_FIELD_W-1:0] req_read_col,
   input  wire logic [ROW_FIELD_W-1:0] req_read_row,
   output logic [COL_FIELD_W-1:0]      rsp_cursor_col,
   output logic [ROW_FIELD_W-1:0]      rsp_cursor_row,
   output logic [CHAR_W-1:0]           rsp_cell_value,
   output logic                        rsp_read_out_of_range
);

   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int NCW   = $clog2(MAX_COLS + 1);
   localparam int NRW   = $clog2(MAX_ROWS + 1);
   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LUT_N = 2 ** CW;

   logic [COLS_CFG_W-1:0] cols_ff;
   logic [ROWS_CFG_W-1:0] rows_ff;
   logic [NCW-1:0]        ecols;
   logic [NRW-1:0]        erows;

   logic [CW-1:0] cur_col_ff, col_in, sc;
   logic [RW-1:0] cur_row_ff, row_in, sr;
   logic          op_read_ff, bad_ff;

   logic [CMP_W-1:0] tab_lut [LUT_N];
   logic [CMP_W-1:0] tab_nxt, col_inc, row_inc;
   logic             is_char, do_store, new_line, wipe_all, do_scroll, rd_bad;

   logic [CW-1:0] scan_col_ff;
   logic [RW-1:0] scan_row_ff;
   logic [CW-1:0] col_lim;
   logic          col_last, row_last;
   logic [AW-1:0] scan_addr, char_addr, read_addr;

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rdata_ff;
   logic              cp_pend_ff;
   logic [AW-1:0]     cp_addr_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [CHAR_W-1:0] mem_wdata;

   logic [COL_FIELD_W-1:0] out_col_ff;
   logic [ROW_FIELD_W-1:0] out_row_ff;
   logic [CHAR_W-1:0]      out_val_ff;
   logic                   out_bad_ff;

   // Next tab stop for every column, fixed at elaboration.
   for (genvar i = 0; i < LUT_N; i++) begin : g_tab
      assign tab_lut[i] = CMP_W'((i / TAB_STOP + 1) * TAB_STOP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_COLS_IN_USE) begin
            cols_ff <= COLS_CFG_W'(csr_data);
         end
         if (csr_index == CSR_ROWS_IN_USE) begin
            rows_ff <= ROWS_CFG_W'(csr_data);
         end
      end
   end

   // Register values outside the legal range act as the nearest legal one.
   always_comb begin
      if (cols_ff == '0) begin
         ecols = NCW'(1);
      end else if (CMP_W'(cols_ff) > CMP_W'(MAX_COLS)) begin
         ecols = NCW'(MAX_COLS);
      end else begin
         ecols = NCW'(cols_ff);
      end
      if (rows_ff == '0) begin
         erows = NRW'(1);
      end else if (CMP_W'(rows_ff) > CMP_W'(MAX_ROWS)) begin
         erows = NRW'(MAX_ROWS);
      end else begin
         erows = NRW'(rows_ff);
      end
   end

   assign sc = (CMP_W'(cur_col_ff) >= CMP_W'(ecols)) ? CW'(ecols - NCW'(1)) : cur_col_ff;
   assign sr = (CMP_W'(cur_row_ff) >= CMP_W'(erows)) ? RW'(erows - NRW'(1)) : cur_row_ff;

   assign is_char = (req_operation == OP_CHAR);
   assign tab_nxt = tab_lut[sc];
   assign col_inc = CMP_W'(sc) + CMP_W'(1);
   assign row_inc = CMP_W'(sr) + CMP_W'(1);

   always_comb begin
      col_in    = sc;
      row_in    = sr;
      do_store  = 1'b0;
      new_line  = 1'b0;
      wipe_all  = 1'b0;
      do_scroll = 1'b0;
      case (req_char_code)
         CHAR_BS, CHAR_DEL: begin
            if (sc != '0) begin
               col_in = sc - CW'(1);
            end
         end
         CHAR_HT: begin
            col_in = (tab_nxt >= CMP_W'(ecols)) ? CW'(ecols - NCW'(1)) : CW'(tab_nxt);
         end
         CHAR_LF: begin
            col_in   = '0;
            new_line = 1'b1;
         end
         CHAR_VT: begin
            new_line = 1'b1;
         end
         CHAR_FF: begin
            col_in   = '0;
            row_in   = '0;
            wipe_all = 1'b1;
         end
         CHAR_CR: begin
            col_in = '0;
         end
         default: begin
            do_store = 1'b1;
            if (col_inc >= CMP_W'(ecols)) begin
               col_in   = '0;
               new_line = 1'b1;
            end else begin
               col_in = CW'(col_inc);
            end
         end
      endcase
      if (new_line) begin
         if (row_inc < CMP_W'(erows)) begin
            row_in = RW'(row_inc);
         end else begin
            row_in    = RW'(erows - NRW'(1));
            do_scroll = 1'b1;
         end
      end
   end

   assign rd_bad = (CMP_W'(req_read_col) >= CMP_W'(ecols)) ||
                   (CMP_W'(req_read_row) >= CMP_W'(erows));

   assign status.need_clear = is_char & wipe_all;
   assign status.need_fill  = is_char & do_scroll;
   assign status.need_copy  = is_char & do_scroll & (erows != NRW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else if (cmd.accept && is_char) begin
         cur_col_ff <= col_in;
         cur_row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_read_ff <= !is_char;
         bad_ff     <= rd_bad;
      end
   end

   // Scan over rows and columns for clearing, scrolling and filling.
   assign col_lim  = (cmd.mode == SCAN_CLEAR) ? CW'(MAX_COLS - 1) : CW'(ecols - NCW'(1));
   assign col_last = (scan_col_ff == col_lim);
   assign row_last = (cmd.mode == SCAN_CLEAR) ? (scan_row_ff == RW'(MAX_ROWS - 1))
                                              : (scan_row_ff == RW'(erows - NRW'(1)));
   assign status.scan_last = col_last & row_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff <= '0;
         scan_row_ff <= '0;
      end else if (cmd.scan_start) begin
         scan_col_ff <= '0;
         case (cmd.mode)
            SCAN_COPY: scan_row_ff <= RW'(1);
            SCAN_FILL: scan_row_ff <= RW'(erows - NRW'(1));
            default:   scan_row_ff <= '0;
         endcase
      end else if (cmd.scan_step) begin
         if (col_last) begin
            scan_col_ff <= '0;
            scan_row_ff <= scan_row_ff + RW'(1);
         end else begin
            scan_col_ff <= scan_col_ff + CW'(1);
         end
      end
   end

   assign scan_addr = AW'(scan_row_ff) * AW'(MAX_COLS) + AW'(scan_col_ff);
   assign char_addr = AW'(sr) * AW'(MAX_COLS) + AW'(sc);
   assign read_addr = AW'(RW'(req_read_row)) * AW'(MAX_COLS) + AW'(CW'(req_read_col));

   // A scroll copy reads the source cell and writes it one row up in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cp_pend_ff <= 1'b0;
      end else begin
         cp_pend_ff <= cmd.scan_step && (cmd.mode == SCAN_COPY);
      end
   end

   always_ff @(posedge clock) begin
      cp_addr_ff <= scan_addr - AW'(MAX_COLS);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = scan_addr;
      mem_wdata = '0;
      if (cp_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = cp_addr_ff;
         mem_wdata = rdata_ff;
      end else if (cmd.accept && is_char && do_store) begin
         mem_we    = 1'b1;
         mem_waddr = char_addr;
         mem_wdata = req_char_code;
      end else if (cmd.scan_step && (cmd.mode == SCAN_CLEAR)) begin
         mem_we = 1'b1;
      end else if (cmd.scan_step && (cmd.mode == SCAN_FILL)) begin
         mem_we    = 1'b1;
         mem_wdata = CHAR_SPACE;
      end
   end

   assign mem_re    = cmd.accept || (cmd.scan_step && (cmd.mode == SCAN_COPY));
   assign mem_raddr = (cmd.scan_step && (cmd.mode == SCAN_COPY)) ? scan_addr : read_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_col_ff <= COL_FIELD_W'(cur_col_ff);
         out_row_ff <= ROW_FIELD_W'(cur_row_ff);
         out_val_ff <= (op_read_ff && !bad_ff) ? rdata_ff : '0;
         out_bad_ff <= op_read_ff & bad_ff;
      end
   end

   assign rsp_cursor_col        = out_col_ff;
   assign rsp_cursor_row        = out_row_ff;
   assign rsp_cell_value        = out_val_ff;
   assign rsp_read_out_of_range = out_bad_ff;

endmodule

`default_nettype wire
